// ===== src/asfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_pkg: shared types and constants of the sample frame packer
// Beat payloads, the classified frame carried from front to back, the
// per-axis split helpers and the frame layout constants.
// ----------------------------------------------------------------------------
package asfp_pkg;

  localparam int unsigned FRAME_BYTES   = 17;
  localparam int unsigned IDX_W         = 5;
  localparam logic [IDX_W-1:0] BYTE_FIRST = IDX_W'(0);
  localparam logic [IDX_W-1:0] BYTE_LAST  = IDX_W'(FRAME_BYTES - 1);
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [15:0] WINDOW_RESET  = 16'd51;
  localparam logic [7:0]  FILL_BYTE     = 8'hFF;
  localparam logic [15:0] MILLI_SCALE   = 16'd1000;
  // floor(m / 1000) == (m * RECIP) >> RECIP_SHIFT for every 16-bit m
  localparam int unsigned RECIP_SHIFT   = 26;
  localparam int unsigned PROD_W        = 34;
  localparam logic [PROD_W-1:0] RECIP   = PROD_W'(67109);

  typedef struct packed {
    logic signed [15:0] accel_x_milli;
    logic signed [15:0] accel_y_milli;
    logic signed [15:0] accel_z_milli;
  } sample_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_frame;
    logic             window_complete;
  } result_t;

  typedef struct packed {
    logic       nonneg;
    logic [7:0] whole;
    logic [9:0] frac;
  } axis_t;

  typedef struct packed {
    axis_t       ax_x;
    axis_t       ax_y;
    axis_t       ax_z;
    logic [15:0] counter;
    logic [7:0]  checksum;
    logic        complete;
  } frame_t;

  // magnitude of a two's complement value, -32768 maps to 32768
  function automatic logic [15:0] magnitude(input logic [15:0] v);
    logic [15:0] neg_v;
    neg_v = 16'(~v + 16'd1);
    return v[15] ? neg_v : v;
  endfunction

  // integer part of m / 1000 by reciprocal multiply
  function automatic logic [7:0] whole_of(input logic [15:0] m);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(m) * RECIP;
    return prod[RECIP_SHIFT +: 8];
  endfunction

  // remainder once the integer part is known
  function automatic logic [9:0] frac_of(input logic [15:0] m, input logic [7:0] w);
    logic [23:0] scaled;
    logic [15:0] rem;
    scaled = 24'(w) * 24'(MILLI_SCALE);
    rem    = 16'(24'(m) - scaled);
    return rem[9:0];
  endfunction

  // byte sum of one axis group
  function automatic logic [7:0] axis_sum(input axis_t a);
    return 8'({7'd0, a.nonneg}) + a.whole + a.frac[7:0] + {6'd0, a.frac[9:8]};
  endfunction

endpackage

// ===== src/asfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_front: sample intake and classification
// Takes sample beats, numbers them against the window length, splits each
// axis into sign, integer and fraction and forms the checksum.
// ----------------------------------------------------------------------------
module asfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  asfp_pkg::sample_t   sample,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic                q_push,
  input  logic                q_full,
  output asfp_pkg::frame_t    q_data
);

  logic        accept;
  logic [15:0] window_length;
  logic [15:0] counter;
  logic [16:0] count_inc;
  logic        wrap;

  // stage 1: magnitudes and numbering
  logic              s1_valid;
  logic [2:0][15:0]  s1_mag;
  logic [2:0]        s1_nonneg;
  logic [15:0]       s1_counter;
  logic              s1_complete;
  logic              s1_ready;

  // stage 2: integer parts
  logic              s2_valid;
  logic [2:0][15:0]  s2_mag;
  logic [2:0]        s2_nonneg;
  logic [2:0][7:0]   s2_whole;
  logic [15:0]       s2_counter;
  logic              s2_complete;
  logic              s2_ready;

  logic [2:0][15:0]  in_raw;
  asfp_pkg::axis_t [2:0] axes;

  assign in_raw   = {sample.accel_z_milli, sample.accel_y_milli, sample.accel_x_milli};
  assign s2_ready = !s2_valid || !q_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready;
  assign accept   = push && s1_ready;

  assign count_inc = 17'(counter) + 17'd1;
  assign wrap      = count_inc >= 17'(window_length);

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= asfp_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_data;
    end
  end

  // sample counter, wraps at the end of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (accept) begin
      counter <= wrap ? 16'd0 : count_inc[15:0];
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag[i]    <= asfp_pkg::magnitude(in_raw[i]);
        s1_nonneg[i] <= !in_raw[i][15];
      end
      s1_counter  <= counter;
      s1_complete <= wrap;
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        s2_whole[i] <= asfp_pkg::whole_of(s1_mag[i]);
      end
      s2_mag      <= s1_mag;
      s2_nonneg   <= s1_nonneg;
      s2_counter  <= s1_counter;
      s2_complete <= s1_complete;
    end
  end

  // fractions and checksum into the queue
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axes[i].nonneg = s2_nonneg[i];
      axes[i].whole  = s2_whole[i];
      axes[i].frac   = asfp_pkg::frac_of(s2_mag[i], s2_whole[i]);
    end
    q_data.ax_x     = axes[0];
    q_data.ax_y     = axes[1];
    q_data.ax_z     = axes[2];
    q_data.counter  = s2_counter;
    q_data.complete = s2_complete;
    q_data.checksum = s2_counter[15:8] + s2_counter[7:0] + asfp_pkg::axis_sum(axes[0])
                    + asfp_pkg::axis_sum(axes[1]) + asfp_pkg::axis_sum(axes[2]);
  end

  assign q_push = s2_valid && !q_full;

  // counter steps by one or wraps to zero on each accepted beat
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (counter == 16'd0) || (counter == 16'($past(counter) + 16'd1)))
    else $error("sample counter skipped a value");

  // a stalled stage 1 keeps its sample
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_counter))
    else $error("stage 1 lost a sample under stall");

  // a stalled stage 2 keeps its sample
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && q_full |=> s2_valid && $stable(s2_counter))
    else $error("stage 2 lost a sample under stall");

endmodule

// ===== src/asfp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_fifo: frame queue between front and back
// Small register queue of classified frames, first word fall-through.
// ----------------------------------------------------------------------------
module asfp_fifo #(
  parameter int unsigned DEPTH = asfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  asfp_pkg::frame_t wr_data,
  output logic             full,
  input  logic             rd,
  output asfp_pkg::frame_t rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  asfp_pkg::frame_t [DEPTH-1:0] entries;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");

  // fill count tracks the pointer distance
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill count");

  a_count_move: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == CNT_W'($past(count) + 1'b1))
    else $error("queue write not counted");

endmodule

// ===== src/asfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_back: frame serializer
// Pulls one classified frame at a time and sends its 17 bytes, byte 0
// first, through an output register.
// ----------------------------------------------------------------------------
module asfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  asfp_pkg::frame_t  q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output asfp_pkg::result_t result
);

  asfp_pkg::frame_t               cur;
  logic                           busy;
  logic [asfp_pkg::IDX_W-1:0]     idx;
  logic                           out_valid;
  logic                           advance;
  logic                           at_last;
  logic [7:0]                     sel_byte;

  assign advance = !out_valid || pop;
  assign at_last = idx == asfp_pkg::BYTE_LAST;
  assign q_pop   = !q_empty && advance && (!busy || at_last);
  assign empty   = !out_valid;

  // byte at the current frame position
  always_comb begin
    unique case (idx)
      5'd0:    sel_byte = cur.checksum;
      5'd1:    sel_byte = cur.counter[15:8];
      5'd2:    sel_byte = cur.counter[7:0];
      5'd3:    sel_byte = {7'd0, cur.ax_x.nonneg};
      5'd4:    sel_byte = cur.ax_x.whole;
      5'd5:    sel_byte = cur.ax_x.frac[7:0];
      5'd6:    sel_byte = {6'd0, cur.ax_x.frac[9:8]};
      5'd7:    sel_byte = {7'd0, cur.ax_y.nonneg};
      5'd8:    sel_byte = cur.ax_y.whole;
      5'd9:    sel_byte = cur.ax_y.frac[7:0];
      5'd10:   sel_byte = {6'd0, cur.ax_y.frac[9:8]};
      5'd11:   sel_byte = {7'd0, cur.ax_z.nonneg};
      5'd12:   sel_byte = cur.ax_z.whole;
      5'd13:   sel_byte = cur.ax_z.frac[7:0];
      5'd14:   sel_byte = {6'd0, cur.ax_z.frac[9:8]};
      default: sel_byte = asfp_pkg::FILL_BYTE;
    endcase
  end

  // byte position and frame load
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= asfp_pkg::BYTE_FIRST;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= asfp_pkg::BYTE_FIRST;
    end else if (advance && busy) begin
      idx <= at_last ? asfp_pkg::BYTE_FIRST : asfp_pkg::IDX_W'(idx + 1'b1);
      if (at_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      result.frame_byte      <= sel_byte;
      result.byte_index      <= idx;
      result.last_of_frame   <= at_last;
      result.window_complete <= cur.complete;
    end
  end

  // held beat stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("output beat changed under stall");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.last_of_frame == (result.byte_index == asfp_pkg::BYTE_LAST))
    else $error("last flag off the final byte");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= asfp_pkg::BYTE_LAST)
    else $error("byte position past end of frame");

  // bytes of one frame follow in order
  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && pop && busy && (idx != asfp_pkg::BYTE_FIRST) |=>
      result.byte_index == asfp_pkg::IDX_W'($past(result.byte_index) + 1'b1))
    else $error("frame bytes out of order");

endmodule

// ===== src/accel_sample_frame_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_sample_frame_packer: accelerometer sample to 17-byte frame
// A sample beat (x, y, z in signed milli-g) becomes 17 byte beats: checksum,
// sample counter, and a sign / integer / fraction group per axis, then two
// fill bytes. The counter wraps after window_length samples and every byte
// of a window's last frame carries window_complete.
//
// Input side: a beat is taken when push is high and full is low.
// Output side: the oldest byte beat sits on result while empty is low and
// leaves when pop is high. cfg_we loads window_length from cfg_data; write
// it only while no frame is in flight.
// A sample passes stage 1, stage 2, the queue, the serializer's frame register
// and the output register. One byte per cycle while pop is held, set by the
// single byte output; up to QUEUE_DEPTH frames wait in the queue ahead of the
// serializer so the input keeps flowing while the output drains. Reset: clears
// all beats in flight, the counter goes to 0 and window_length to 51. A stalled
// receiver holds its byte; full rises once the queue and stages 1 and 2 fill.
// ----------------------------------------------------------------------------
module accel_sample_frame_packer #(
  parameter int unsigned QUEUE_DEPTH = asfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  asfp_pkg::sample_t sample,
  output logic              empty,
  input  logic              pop,
  output asfp_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  asfp_pkg::frame_t q_wr_data;
  asfp_pkg::frame_t q_rd_data;

  // intake and classification
  asfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_wr_data)
  );

  // decoupling queue
  asfp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // byte serializer
  asfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
